/* rtl/modbus_rtu_poll_master_assert.svh */
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master assertion macros
// shared property forms for the poll master checks
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_POLL_MASTER_ASSERT_SVH
`define MODBUS_RTU_POLL_MASTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MRPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mrpm_pkg.sv */
// ----------------------------------------------------------------------------
// mrpm_pkg
// shared types, frame constants and request byte tables of the poll master
// ----------------------------------------------------------------------------
package mrpm_pkg;

	// receive store
	localparam int RX_DEPTH = 50;
	localparam int CNT_W    = $clog2(RX_DEPTH + 1);
	localparam int ADDR_W   = $clog2(RX_DEPTH);

	// poll timing
	localparam int AGE_W = 24;
	localparam logic [AGE_W-1:0] AGE_MAX  = '1;
	localparam logic [AGE_W-1:0] POLL_RST = 24'd10000;
	localparam logic [AGE_W-1:0] TMO_RST  = 24'd2000;

	// channel widths
	localparam int IDATA_W = 8;
	localparam int ODATA_W = 64;
	localparam int OUSER_W = 2;
	localparam int CFG_IDX_W = 1;

	// input item kind
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_BYTE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT  = 1'b1;

	// slave addresses
	localparam logic [1:0] UNIT_A = 2'd1;
	localparam logic [1:0] UNIT_B = 2'd2;

	// request frame
	localparam logic [7:0] FUNC_READ = 8'h03;
	localparam logic [7:0] START_HI  = 8'h03;
	localparam logic [7:0] START_LO  = 8'h0D;
	localparam logic [7:0] COUNT_HI  = 8'h00;
	localparam logic [7:0] COUNT_LO  = 8'h14;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int REQ_BYTES = 8;
	localparam int HDR_BYTES = 6;
	localparam int REQ_IDX_W = $clog2(REQ_BYTES);
	localparam logic [REQ_IDX_W-1:0] REQ_LAST = REQ_IDX_W'(REQ_BYTES - 1);

	// response frame: length byte plus address, function, length and crc
	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] LEN_OVERHEAD = 9'd5;
	localparam logic [CNT_W-1:0] TOTAL_MIN = CNT_W'(20);
	localparam logic [CNT_W-1:0] TODAY_MIN = CNT_W'(46);

	// readout of the word bytes after a complete frame
	localparam int READ_N   = 8;
	localparam int RD_IDX_W = $clog2(READ_N + 1);
	localparam logic [RD_IDX_W-1:0] READ_DONE = RD_IDX_W'(READ_N);

	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_OFFLINE = 2'd1,
		KIND_READING = 2'd2
	} kind_t;

	typedef struct packed {
		logic        today_valid;
		logic [15:0] today_energy_tenths;
		logic        total_valid;
		logic [15:0] total_energy_tenths;
		logic        unit_working;
		logic [15:0] grid_power_watts;
	} reading_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] unit;
		reading_t   rd;
	} job_t;

	typedef struct packed {
		logic [1:0] polled_unit;
		logic       clear_count;
	} rx_ctl_t;

	typedef struct packed {
		logic busy;
		logic complete;
	} rx_sts_t;

	function automatic logic [7:0] hdr_byte(input logic [1:0] unit,
		input logic [REQ_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = {6'b0, unit};
			3'd1: b = FUNC_READ;
			3'd2: b = START_HI;
			3'd3: b = START_LO;
			3'd4: b = COUNT_HI;
			default: b = COUNT_LO;
		endcase
		return b;
	endfunction

	// crc-16 over the six header bytes, evaluated at elaboration only
	function automatic logic [15:0] req_crc(input logic [1:0] unit);
		logic [15:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < HDR_BYTES; i++) begin
			crc = crc ^ {8'h00, hdr_byte(unit, REQ_IDX_W'(i))};
			for (int j = 0; j < 8; j++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		return crc;
	endfunction

	localparam logic [15:0] CRC_A = req_crc(UNIT_A);
	localparam logic [15:0] CRC_B = req_crc(UNIT_B);

	function automatic logic [7:0] req_byte(input logic [1:0] unit,
		input logic [REQ_IDX_W-1:0] idx);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = (unit == UNIT_B) ? CRC_B : CRC_A;
		case (idx)
			3'd6: b = crc[7:0];
			3'd7: b = crc[15:8];
			default: b = hdr_byte(unit, idx);
		endcase
		return b;
	endfunction

	// store positions of power, status, total and today words, high byte first
	function automatic logic [ADDR_W-1:0] rd_addr(input logic [2:0] i);
		logic [ADDR_W-1:0] a;
		unique case (i)
			3'd0: a = ADDR_W'(3);
			3'd1: a = ADDR_W'(4);
			3'd2: a = ADDR_W'(5);
			3'd3: a = ADDR_W'(6);
			3'd4: a = ADDR_W'(15);
			3'd5: a = ADDR_W'(16);
			3'd6: a = ADDR_W'(41);
			3'd7: a = ADDR_W'(42);
		endcase
		return a;
	endfunction

endpackage

/* rtl/mrpm_ram.sv */
// ----------------------------------------------------------------------------
// mrpm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mrpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/mrpm_rx.sv */
// ----------------------------------------------------------------------------
// mrpm_rx
// response collector: byte store in ram, frame sync, word readout
// ----------------------------------------------------------------------------
`include "modbus_rtu_poll_master_assert.svh"

module mrpm_rx import mrpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [7:0]   rx_byte,
	input  rx_ctl_t      ctl,
	output rx_sts_t      sts,
	output logic         job_valid,
	output job_t         job,
	input  logic         job_take
);

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_READ,
		RX_HOLD
	} rx_state_t;

	rx_state_t            state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [7:0]           sh0_q, sh1_q, sh2_q;
	logic [RX_DEPTH-1:0]  vld_q;
	logic [RD_IDX_W-1:0]  rd_idx_q;
	logic                 rd_vld_q;
	logic [63:0]          words_q;
	logic [CNT_W-1:0]     frame_cnt_q;

	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [7:0]           s0_n, s1_n, s2_n;
	logic [CNT_W-1:0]     cnt_sync, cnt_n;
	logic                 complete;
	logic                 rd_en;
	logic [ADDR_W-1:0]    raddr;
	logic [7:0]           ram_q;
	logic [7:0]           rd_byte;

	always_comb begin
		wr_en   = go && (cnt_q < CNT_W'(RX_DEPTH));
		wr_addr = cnt_q[ADDR_W-1:0];
		s0_n    = (wr_en && cnt_q == CNT_W'(0)) ? rx_byte : sh0_q;
		s1_n    = (wr_en && cnt_q == CNT_W'(1)) ? rx_byte : sh1_q;
		s2_n    = (wr_en && cnt_q == CNT_W'(2)) ? rx_byte : sh2_q;
		// address mismatch restarts, then a bad function byte restarts
		cnt_sync = (s0_n != {6'b0, ctl.polled_unit}) ? '0 : cnt_q;
		if (cnt_sync == CNT_W'(1) && s1_n != FUNC_READ) begin
			cnt_sync = '0;
		end
		cnt_n = wr_en ? cnt_sync + CNT_W'(1) : '0;
		complete = go && (s0_n == {6'b0, ctl.polled_unit}) && (s1_n == FUNC_READ)
			&& ({{(LEN_W-CNT_W){1'b0}}, cnt_n} == {1'b0, s2_n} + LEN_OVERHEAD);
	end

	assign rd_en   = (state_q == RX_READ) && (rd_idx_q != READ_DONE);
	assign raddr   = rd_addr(rd_idx_q[2:0]);
	assign rd_byte = rd_vld_q ? ram_q : 8'h00;

	mrpm_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(rx_byte),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RX_IDLE;
			cnt_q       <= '0;
			sh0_q       <= '0;
			sh1_q       <= '0;
			sh2_q       <= '0;
			vld_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			words_q     <= '0;
			frame_cnt_q <= '0;
		end else begin
			if (ctl.clear_count) begin
				cnt_q <= '0;
			end else if (go) begin
				cnt_q <= cnt_n;
				sh0_q <= s0_n;
				sh1_q <= s1_n;
				sh2_q <= s2_n;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[raddr];
			end
			unique case (state_q)
				RX_IDLE: begin
					if (complete) begin
						state_q     <= RX_READ;
						rd_idx_q    <= '0;
						frame_cnt_q <= cnt_n;
					end
				end
				RX_READ: begin
					// the registered read data here belongs to the read issued on the previous pass
					if (rd_idx_q != '0) begin
						words_q <= {words_q[55:0], rd_byte};
					end
					if (rd_idx_q == READ_DONE) begin
						state_q <= RX_HOLD;
					end else begin
						rd_idx_q <= rd_idx_q + RD_IDX_W'(1);
					end
				end
				RX_HOLD: begin
					if (job_take) begin
						state_q <= RX_IDLE;
					end
				end
				default: state_q <= RX_IDLE;
			endcase
		end
	end

	always_comb begin
		job.kind = KIND_READING;
		job.unit = sh0_q[1:0];
		job.rd.grid_power_watts    = words_q[63:48];
		job.rd.unit_working        = (words_q[47:32] != 16'h0000);
		job.rd.total_valid         = (frame_cnt_q >= TOTAL_MIN);
		job.rd.total_energy_tenths = job.rd.total_valid ? words_q[31:16] : 16'h0000;
		job.rd.today_valid         = (frame_cnt_q >= TODAY_MIN);
		job.rd.today_energy_tenths = job.rd.today_valid ? words_q[15:0] : 16'h0000;
	end

	assign job_valid    = (state_q == RX_HOLD);
	assign sts.busy     = (state_q != RX_IDLE);
	assign sts.complete = complete;

	`MRPM_ASSERT_NOW(a_rx_go_idle, go, state_q == RX_IDLE, "byte taken during frame readout")
	`MRPM_ASSERT_NEXT(a_rx_read_end, state_q == RX_READ && rd_idx_q == READ_DONE,
		state_q == RX_HOLD, "readout did not end in hold")

endmodule

/* rtl/mrpm_ctrl.sv */
// ----------------------------------------------------------------------------
// mrpm_ctrl
// poll scheduler: tick aging, poll and timeout decisions, config registers
// ----------------------------------------------------------------------------
module mrpm_ctrl import mrpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic                 action,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [AGE_W-1:0]     cfg_wdata,
	input  rx_sts_t              rx_sts,
	output rx_ctl_t              rx_ctl,
	output logic                 job_valid,
	output job_t                 job
);

	logic [AGE_W-1:0] poll_q, tmo_q, age_q;
	logic             await_q, seen_q;
	logic [1:0]       unit_q;

	logic [AGE_W-1:0] age_inc;
	logic             is_tick, poll_hit, tmo_hit;
	logic [1:0]       next_unit;

	always_comb begin
		is_tick   = go && (action == ACT_TICK);
		age_inc   = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);
		poll_hit  = !await_q && ((age_inc > poll_q) || (age_inc == AGE_MAX));
		tmo_hit   = await_q && (age_inc > tmo_q);
		next_unit = (unit_q == UNIT_B) ? UNIT_A : UNIT_B;
	end

	always_comb begin
		job_valid = is_tick && (poll_hit || (tmo_hit && !seen_q));
		job.kind  = poll_hit ? KIND_REQUEST : KIND_OFFLINE;
		job.unit  = poll_hit ? next_unit : unit_q;
		job.rd    = '0;
		rx_ctl.polled_unit = unit_q;
		rx_ctl.clear_count = is_tick && poll_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q  <= POLL_RST;
			tmo_q   <= TMO_RST;
			age_q   <= AGE_MAX;
			await_q <= 1'b0;
			seen_q  <= 1'b0;
			unit_q  <= UNIT_A;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_POLL_INTERVAL: poll_q <= cfg_wdata;
					CFG_RESP_TIMEOUT:  tmo_q  <= cfg_wdata;
				endcase
			end
			if (is_tick) begin
				if (poll_hit) begin
					age_q   <= '0;
					await_q <= 1'b1;
					seen_q  <= 1'b0;
					unit_q  <= next_unit;
				end else begin
					age_q <= age_inc;
					if (tmo_hit) begin
						await_q <= 1'b0;
					end
				end
			end else if (go) begin
				seen_q <= 1'b1;
				if (rx_sts.complete) begin
					await_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/mrpm_emit.sv */
// ----------------------------------------------------------------------------
// mrpm_emit
// result sequencer: holds one report and plays it out beat by beat
// ----------------------------------------------------------------------------
`include "modbus_rtu_poll_master_assert.svh"

module mrpm_emit import mrpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  job_t               job_in,
	output logic               can_load,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,
	output logic [OUSER_W-1:0] m_tuser,
	output logic               m_tlast
);

	logic                 valid_q;
	job_t                 job_q;
	logic [REQ_IDX_W-1:0] idx_q;
	logic [7:0]           tx;
	logic                 beat;

	always_comb begin
		tx       = (job_q.kind == KIND_REQUEST) ? req_byte(job_q.unit, idx_q) : 8'h00;
		m_tvalid = valid_q;
		m_tuser  = OUSER_W'(job_q.kind);
		m_tdata  = {{(ODATA_W - $bits(reading_t) - 10){1'b0}}, job_q.rd, job_q.unit, tx};
		m_tlast  = (job_q.kind != KIND_REQUEST) || (idx_q == REQ_LAST);
		beat     = valid_q && m_tready;
		can_load = !valid_q || (m_tready && m_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			job_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				job_q   <= job_in;
				idx_q   <= '0;
			end else if (beat && m_tlast) begin
				valid_q <= 1'b0;
			end else if (beat) begin
				idx_q <= idx_q + REQ_IDX_W'(1);
			end
		end
	end

	`MRPM_ASSERT_NOW(a_emit_load_free, load, can_load, "report loaded over a running one")
	`MRPM_ASSERT_NOW(a_emit_single_beat, valid_q && job_q.kind != KIND_REQUEST,
		idx_q == '0, "single-beat report with nonzero beat index")

endmodule

/* rtl/modbus_rtu_poll_master.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master
// modbus rtu master polling two slaves with read holding registers requests
// ----------------------------------------------------------------------------
// usage
//   s_* carries input items: s_tuser low is a millisecond tick, high is one
//   received serial byte in s_tdata. m_* carries reports: m_tuser is the kind
//   (request byte, unit offline, unit reading), m_tlast marks the last beat
//   an input item causes. cfg_* writes poll interval (index 0) and response
//   timeout (index 1); it is always ready and meant for idle periods.
//   an item enters a one-deep input stage and is decided once go allows. a
//   poll tick plays out 8 request beats, one per cycle while m_tready is high;
//   a timeout with no byte since the poll gives one offline beat. a byte that
//   completes a frame starts a readout of 8 store bytes through the single ram
//   read port, then holds the reading for the sequencer. other bytes go back
//   to back while the store is idle, also while a report waits on m_tready; a
//   tick waits for a free sequencer. when the receiver stalls, the report
//   holds and a tick or held reading stops input. reset clears the store valid
//   bits at once, no sweep; the first tick after reset starts a poll of unit 2.
// ----------------------------------------------------------------------------
module modbus_rtu_poll_master import mrpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IDATA_W-1:0]   s_tdata,   // rx_byte
	input  logic                 s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tx_byte, unit_address, grid_power_watts, unit_working,
	// total_energy_tenths, total_valid, today_energy_tenths, today_valid
	output logic [ODATA_W-1:0]   m_tdata,
	output logic [OUSER_W-1:0]   m_tuser,   // report_kind
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AGE_W-1:0]     cfg_data
);

	logic         valid_s1;
	logic         action_s1;
	logic [7:0]   byte_s1;

	logic         go;
	rx_ctl_t      rx_ctl;
	rx_sts_t      rx_sts;
	logic         ctrl_job_valid, rx_job_valid;
	job_t         ctrl_job, rx_job;
	logic         can_load, rx_take, emit_load;
	job_t         emit_job;

	// a tick may emit, so it waits for a free sequencer; a byte only needs the store
	assign go = valid_s1 && !rx_sts.busy && ((action_s1 == ACT_BYTE) || can_load);
	assign s_tready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			action_s1 <= ACT_TICK;
			byte_s1   <= '0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			if (s_tvalid) begin
				action_s1 <= s_tuser;
				byte_s1   <= s_tdata;
			end
		end
	end

	mrpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.action   (action_s1),
		.cfg_we   (cfg_valid),
		.cfg_idx  (cfg_index),
		.cfg_wdata(cfg_data),
		.rx_sts   (rx_sts),
		.rx_ctl   (rx_ctl),
		.job_valid(ctrl_job_valid),
		.job      (ctrl_job)
	);

	mrpm_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go && (action_s1 == ACT_BYTE)),
		.rx_byte  (byte_s1),
		.ctl      (rx_ctl),
		.sts      (rx_sts),
		.job_valid(rx_job_valid),
		.job      (rx_job),
		.job_take (rx_take)
	);

	// a held reading and a decided tick never meet: go waits while rx is busy
	assign rx_take   = rx_job_valid && can_load;
	assign emit_load = rx_take || ctrl_job_valid;
	assign emit_job  = rx_job_valid ? rx_job : ctrl_job;

	mrpm_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (emit_load),
		.job_in  (emit_job),
		.can_load(can_load),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
